// ----- hw/rtl/ttspp_pkg.sv -----
// Package for the top-two spectral peak picker: widths, constants and the
// word types shared between the tracker, the frequency stage and the top level.
// No dependencies.
package ttspp_pkg;

   // spectrum and field geometry
   localparam int unsigned FftPoints = 8192;
   localparam int unsigned FftLog2   = $clog2(FftPoints);
   localparam int unsigned MagW      = 32;
   localparam int unsigned BinW      = 12;
   localparam int unsigned RateW     = 18;
   localparam int unsigned FreqW     = 17;
   localparam int unsigned ProdW     = BinW + RateW;

   // highest bin index the counter reaches, highest bin that can be a peak
   localparam logic [BinW-1:0] CntMax    = {BinW{1'b1}};
   localparam int unsigned     PeakLimit = FftPoints / 2 - 2;
   localparam logic [FreqW-1:0] FreqMax  = {FreqW{1'b1}};

   localparam logic [RateW-1:0] RateReset = RateW'(44100);

   // pair of peak bin indices handed from the tracker to the frequency stage
   typedef struct packed {
      logic [BinW-1:0] best_bin;
      logic [BinW-1:0] second_bin;
   } peak_bins_type;

endpackage

// ----- hw/rtl/ttspp_tracker.sv -----
// Running local-maximum detector and top-two peak tracker, one bin per word.
// Depends on ttspp_pkg.
module ttspp_tracker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  logic [ttspp_pkg::MagW-1:0]    magnitude,
   input  logic                          last_bin,
   output ttspp_pkg::peak_bins_type      peaks
);
   import ttspp_pkg::*;

   logic [BinW-1:0] bin_ff, bin_in;
   logic            overrun_ff, overrun_in;
   logic [MagW-1:0] left_ff, left_in;
   logic [MagW-1:0] centre_ff, centre_in;
   logic [MagW-1:0] best_mag_ff, best_mag_in;
   logic [MagW-1:0] second_mag_ff, second_mag_in;
   logic [BinW-1:0] best_idx_ff, best_idx_in;
   logic [BinW-1:0] second_idx_ff, second_idx_in;
   logic [BinW-1:0] cand;
   logic            is_peak;

   // centre bin is a peak candidate when it is at least the left bin and above the right bin
   always_comb begin
      cand    = bin_ff - BinW'(1);
      is_peak = (bin_ff >= BinW'(2)) && !overrun_ff
                && (32'(cand) <= PeakLimit)
                && (centre_ff >= left_ff) && (centre_ff > magnitude);
   end

   // next state of the window, the trackers and the bin counter
   always_comb begin
      bin_in        = bin_ff;
      overrun_in    = overrun_ff;
      left_in       = left_ff;
      centre_in     = centre_ff;
      best_mag_in   = best_mag_ff;
      second_mag_in = second_mag_ff;
      best_idx_in   = best_idx_ff;
      second_idx_in = second_idx_ff;
      if (fire) begin
         if (bin_ff == '0) begin
            // seed both trackers with the DC bin
            best_mag_in   = magnitude;
            second_mag_in = magnitude;
            best_idx_in   = '0;
            second_idx_in = '0;
         end else if (is_peak) begin
            if (centre_ff > best_mag_ff) begin
               second_mag_in = best_mag_ff;
               second_idx_in = best_idx_ff;
               best_mag_in   = centre_ff;
               best_idx_in   = cand;
            end else if (centre_ff > second_mag_ff) begin
               second_mag_in = centre_ff;
               second_idx_in = cand;
            end
         end
         left_in   = centre_ff;
         centre_in = magnitude;
         // saturate the counter and flag an overlong spectrum
         if (bin_ff == CntMax) begin
            overrun_in = 1'b1;
         end else begin
            bin_in = bin_ff + BinW'(1);
         end
         // restart on the end of the spectrum
         if (last_bin) begin
            bin_in     = '0;
            overrun_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_ff     <= '0;
         overrun_ff <= 1'b0;
      end else begin
         bin_ff     <= bin_in;
         overrun_ff <= overrun_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff       <= left_in;
      centre_ff     <= centre_in;
      best_mag_ff   <= best_mag_in;
      second_mag_ff <= second_mag_in;
      best_idx_ff   <= best_idx_in;
      second_idx_ff <= second_idx_in;
   end

   // indices after this word, valid as a result when it carries last_bin
   assign peaks.best_bin   = best_idx_in;
   assign peaks.second_bin = second_idx_in;

endmodule

// ----- hw/rtl/ttspp_freq.sv -----
// Bin-to-frequency stage: bin * rate / FftPoints, saturated, into the
// result register. Depends on ttspp_pkg.
module ttspp_freq (
   input  logic                          clock,
   input  logic                          load,
   input  ttspp_pkg::peak_bins_type      peaks,
   input  logic [ttspp_pkg::RateW-1:0]   rate_hz,
   output ttspp_pkg::peak_bins_type      bins_out,
   output logic [ttspp_pkg::FreqW-1:0]   best_freq,
   output logic [ttspp_pkg::FreqW-1:0]   second_freq
);
   import ttspp_pkg::*;

   logic [ProdW-1:0]  best_prod, second_prod;
   logic [ProdW-1:0]  best_q, second_q;
   logic [FreqW-1:0]  best_freq_in, second_freq_in;
   peak_bins_type     bins_ff;
   logic [FreqW-1:0]  best_freq_ff, second_freq_ff;

   // scale by the rate, divide by the power-of-two length, clamp to the field
   always_comb begin
      best_prod   = ProdW'(peaks.best_bin) * ProdW'(rate_hz);
      second_prod = ProdW'(peaks.second_bin) * ProdW'(rate_hz);
      best_q      = best_prod >> FftLog2;
      second_q    = second_prod >> FftLog2;
      best_freq_in   = (best_q > ProdW'(FreqMax)) ? FreqMax : best_q[FreqW-1:0];
      second_freq_in = (second_q > ProdW'(FreqMax)) ? FreqMax : second_q[FreqW-1:0];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bins_ff        <= peaks;
         best_freq_ff   <= best_freq_in;
         second_freq_ff <= second_freq_in;
      end
   end

   assign bins_out    = bins_ff;
   assign best_freq   = best_freq_ff;
   assign second_freq = second_freq_ff;

endmodule

// ----- hw/rtl/top_two_spectral_peak_picker.sv -----
// Top-two spectral peak picker. Takes one bin word per cycle, back to back, while ready.
// The peak pair of the word carrying tlast is registered in the s1 stage, then its
// frequencies in the result register, which raises rsp_tvalid (tracker, then result).
// Throughput: one input word per cycle unless a full pipe waits on rsp_tready.
// Reset clears the bin counter, overrun flag and valids; the sample rate returns to 44100.
// Depends on ttspp_pkg, ttspp_tracker and ttspp_freq.
module top_two_spectral_peak_picker (
   input  logic                          clock,
   input  logic                          reset,
   // input stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [31:0]                   req_tdata,   // [31:0] magnitude
   input  logic                          req_tlast,   // last_bin
   // result stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [63:0]                   rsp_tdata,   // [11:0] best_bin, [23:12] second_bin,
                                                      // [40:24] best_freq, [57:41] second_freq
   // configuration
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ttspp_pkg::RateW-1:0]   csr_wdata    // sample rate in hertz
);
   import ttspp_pkg::*;

   logic [RateW-1:0] rate_ff;
   logic             req_fire;
   logic             advance;
   logic             s1_load;
   logic             s1_valid_ff;
   logic             out_valid_ff;
   peak_bins_type    trk_bins;
   peak_bins_type    s1_bins_ff;
   peak_bins_type    out_bins;
   logic [FreqW-1:0] best_freq;
   logic [FreqW-1:0] second_freq;

   // sample rate register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= RateReset;
      end else if (csr_valid) begin
         rate_ff <= csr_wdata;
      end
   end

   // advance the pipe when the result slot is free or being drained
   assign advance    = !out_valid_ff || rsp_tready;
   assign s1_load    = !s1_valid_ff || advance;
   assign req_tready = s1_load;
   assign req_fire   = req_tvalid && req_tready;

   ttspp_tracker u_tracker (
      .clock     (clock),
      .reset     (reset),
      .fire      (req_fire),
      .magnitude (req_tdata[MagW-1:0]),
      .last_bin  (req_tlast),
      .peaks     (trk_bins)
   );

   // hold the final peak pair of a spectrum
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_load) begin
         s1_valid_ff <= req_fire && req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_bins_ff <= trk_bins;
      end
   end

   ttspp_freq u_freq (
      .clock       (clock),
      .load        (advance && s1_valid_ff),
      .peaks       (s1_bins_ff),
      .rate_hz     (rate_ff),
      .bins_out    (out_bins),
      .best_freq   (best_freq),
      .second_freq (second_freq)
   );

   // result word valid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b0, second_freq, best_freq, out_bins.second_bin, out_bins.best_bin};

endmodule
